// File: sv/frkl_pkg.sv
// frkl_pkg: item types, command and status codes and control structs for frame_ring_keep_last
// no dependencies, used by every other file of the block but frkl_ram
package frkl_pkg;

  localparam int CAP_W = 5;
  localparam int NORM_CNT_W = $clog2(CAP_W);
  localparam int CFG_IDX_W = 1;

  localparam logic [2:0] CMD_PUSH      = 3'd0;
  localparam logic [2:0] CMD_ADVANCE   = 3'd1;
  localparam logic [2:0] CMD_READ_CUR  = 3'd2;
  localparam logic [2:0] CMD_READ_NEXT = 3'd3;
  localparam logic [2:0] CMD_READ_LAST = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_ABORT = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_RING_CAPACITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_LAST     = 1'd1;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [63:0] entry_pos;
    logic signed [31:0] entry_serial;
    logic signed [31:0] current_serial;
    logic               abort;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [3:0]         slot_index;
    logic signed [63:0] read_pos;
    logic signed [31:0] read_serial;
    logic [4:0]         remaining;
    logic signed [63:0] last_shown_pos;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic norm_start;
    logic exec;
    logic resp_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic norm_ok;
    logic out_free;
  } ctrl_stat_t;

  // one restoring step of index modulo capacity
  function automatic logic [CAP_W-1:0] mod_step(input logic [CAP_W-1:0] rem,
                                                input logic in_bit,
                                                input logic [CAP_W-1:0] cap);
    logic [CAP_W:0] sh;
    logic [CAP_W:0] df;
    sh = {rem, in_bit};
    df = sh - {1'b0, cap};
    mod_step = (sh >= {1'b0, cap}) ? df[CAP_W-1:0] : sh[CAP_W-1:0];
  endfunction

endpackage

// File: sv/frame_ring_keep_last_top.sv
// frame_ring_keep_last_top: top level of the frame descriptor ring with keep-last entry
// depends on frkl_pkg, frkl_ctrl, frkl_dp (which holds frkl_ram)
//
// Ring of frame descriptors (position, serial) driven by one command per item:
// push, advance, read current, read next or read last shown. Every item gives
// exactly one result item carrying a status code, the slot touched, the slot
// contents for reads, the count of unshown entries and the last shown position
// (-1 when nothing is shown or its serial differs from current_serial). An
// item is first executed against the index and count registers with both ram
// reads issued (S_EXEC), then loaded into the result register once that is
// free (S_RESP); the next item is accepted while the result register is loaded,
// and the result shows on out_ in the cycle after. The first item after a
// ring_capacity write waits in S_NORM while a bit-serial unit reduces both ring
// indices modulo the new capacity, until the sequencer sees that the reduction
// is done. A finished result waits in its own register, so out_stall only
// holds the block once a second result is ready. Slots never written read as
// zero through per-slot valid bits cleared by reset; no clearing pass is needed.
// Configuration (cfg_we, cfg_index, cfg_wdata) must only be written while idle.
module frame_ring_keep_last_top #(
  parameter int RING_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // command items
  input  logic                           in_valid,
  output logic                           in_stall,
  input  frkl_pkg::in_item_t             in_data,
  // result items
  output logic                           out_valid,
  input  logic                           out_stall,
  output frkl_pkg::out_item_t            out_data,
  // configuration writes
  input  logic                           cfg_we,
  input  logic [frkl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [frkl_pkg::CAP_W-1:0]     cfg_wdata
);

  // command and status between sequencer and datapath
  frkl_pkg::ctrl_cmd_t  cmd;
  frkl_pkg::ctrl_stat_t stat;

  // sequencer: accept, optional index reduction, execute, respond
  frkl_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  // datapath: ring state, descriptor ram, result register
  frkl_dp #(
    .RING_DEPTH(RING_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule

// File: sv/frkl_ram.sv
// frkl_ram: generic ram, one write port and two registered read ports with enable
// no dependencies
module frkl_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem_r[raddr_a];
      rdata_b <= mem_r[raddr_b];
    end
  end

endmodule

// File: sv/frkl_ctrl.sv
// frkl_ctrl: sequencer for frame_ring_keep_last, accept / reduce indices / execute / respond
// depends on frkl_pkg
module frkl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  frkl_pkg::ctrl_stat_t stat,
  output frkl_pkg::ctrl_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_NORM = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       take;

  always_comb begin
    in_stall = !((state_r == S_IDLE) || ((state_r == S_RESP) && stat.out_free));
    take = in_valid && !in_stall;
    cmd.accept = take;
    cmd.norm_start = take && !stat.norm_ok;
    cmd.exec = (state_r == S_EXEC);
    cmd.resp_load = (state_r == S_RESP) && stat.out_free;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          state_nxt = stat.norm_ok ? S_EXEC : S_NORM;
        end
      end
      S_NORM: begin
        if (stat.norm_ok) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (take) begin
          state_nxt = stat.norm_ok ? S_EXEC : S_NORM;
        end else if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: sv/frkl_dp.sv
// frkl_dp: ring state, index reduction unit, command execution and result register
// depends on frkl_pkg and frkl_ram
module frkl_dp #(
  parameter int RING_DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  frkl_pkg::ctrl_cmd_t              cmd,
  output frkl_pkg::ctrl_stat_t             stat,
  input  frkl_pkg::in_item_t               in_data,
  input  logic                             cfg_we,
  input  logic [frkl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [frkl_pkg::CAP_W-1:0]       cfg_wdata,
  input  logic                             out_stall,
  output logic                             out_valid,
  output frkl_pkg::out_item_t              out_data
);

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int CW = frkl_pkg::CAP_W;
  localparam int DEPTH_CAP = (RING_DEPTH < 31) ? RING_DEPTH : 31;
  localparam int ENT_W = 96;

  // configuration
  logic [CW-1:0] cap_r;
  logic          keep_r;
  logic [CW-1:0] cap_eff;

  // ring state: raw indices and their reductions modulo the capacity
  logic [CW-1:0] wr_idx_r, rd_idx_r, wm_r, rm_r;
  logic [CW-1:0] occ_r;
  logic          shown_r;
  logic [RING_DEPTH-1:0] valid_r;
  logic          norm_ok_r;

  // index reduction unit
  logic                               norm_busy_r;
  logic [frkl_pkg::NORM_CNT_W-1:0]    norm_cnt_r;
  logic [CW-1:0] xr_r, xw_r, remr_r, remw_r;
  logic [CW-1:0] remr_nxt, remw_nxt;

  frkl_pkg::in_item_t in_r;

  // execute
  logic [1:0]    st;
  logic [CW-1:0] slot;
  logic          hit, wr_en;
  logic [CW-1:0] wr_idx_nxt, wm_nxt, rd_idx_nxt, rm_nxt, occ_nxt;
  logic          shown_nxt;
  logic [CW-1:0] unshown, unshown_nxt;
  logic [CW:0]   cap6, w_inc, r_inc, t1, t2, n1;
  logic [CW-1:0] w_wrap, r_wrap, cur_slot, next_slot;
  logic [IDX_W-1:0] addr_a, addr_b, waddr;
  logic          bypass;

  // response registers
  logic [1:0]    res_st_r;
  logic [CW-1:0] res_slot_r, res_rem_r;
  logic          res_hit_r, res_shown_r, res_bypass_r, va_r, vb_r;

  logic [ENT_W-1:0] rdata_a, rdata_b;
  logic signed [63:0] a_pos, b_pos;
  logic signed [31:0] a_ser, b_ser;
  logic          out_valid_r;
  frkl_pkg::out_item_t out_r;
  frkl_pkg::out_item_t res;

  always_comb begin
    cap_eff = cap_r;
    if (cap_r == '0) begin
      cap_eff = CW'(1);
    end else if (cap_r > CW'(DEPTH_CAP)) begin
      cap_eff = CW'(DEPTH_CAP);
    end
  end

  assign remr_nxt = frkl_pkg::mod_step(remr_r, xr_r[CW-1], cap_eff);
  assign remw_nxt = frkl_pkg::mod_step(remw_r, xw_r[CW-1], cap_eff);

  always_comb begin
    cap6 = {1'b0, cap_eff};
    unshown = (occ_r > CW'(shown_r)) ? occ_r - CW'(shown_r) : '0;
    w_inc = {1'b0, wm_r} + (CW+1)'(1);
    r_inc = {1'b0, rm_r} + (CW+1)'(1);
    w_wrap = (w_inc >= cap6) ? '0 : w_inc[CW-1:0];
    r_wrap = (r_inc >= cap6) ? '0 : r_inc[CW-1:0];
    t1 = {1'b0, rm_r} + (CW+1)'(shown_r);
    cur_slot = (t1 >= cap6) ? CW'(t1 - cap6) : t1[CW-1:0];
    t2 = t1 + (CW+1)'(1);
    n1 = (t2 >= cap6) ? t2 - cap6 : t2;
    next_slot = (n1 >= cap6) ? CW'(n1 - cap6) : n1[CW-1:0];

    st = frkl_pkg::ST_OK;
    slot = '0;
    hit = 1'b0;
    wr_en = 1'b0;
    wr_idx_nxt = wr_idx_r;
    wm_nxt = wm_r;
    rd_idx_nxt = rd_idx_r;
    rm_nxt = rm_r;
    occ_nxt = occ_r;
    shown_nxt = shown_r;
    case (in_r.command)
      frkl_pkg::CMD_PUSH: begin
        if (in_r.abort) begin
          st = frkl_pkg::ST_ABORT;
        end else if (occ_r >= cap_eff) begin
          st = frkl_pkg::ST_FULL;
        end else begin
          slot = wm_r;
          wr_en = 1'b1;
          wr_idx_nxt = w_wrap;
          wm_nxt = w_wrap;
          occ_nxt = occ_r + CW'(1);
        end
      end
      frkl_pkg::CMD_ADVANCE: begin
        if (unshown == '0) begin
          st = frkl_pkg::ST_EMPTY;
        end else begin
          slot = rm_r;
          if (keep_r && !shown_r) begin
            shown_nxt = 1'b1;
          end else begin
            rd_idx_nxt = r_wrap;
            rm_nxt = r_wrap;
            occ_nxt = occ_r - CW'(1);
          end
        end
      end
      frkl_pkg::CMD_READ_CUR: begin
        if (in_r.abort) begin
          st = frkl_pkg::ST_ABORT;
        end else if (unshown == '0) begin
          st = frkl_pkg::ST_EMPTY;
        end else begin
          slot = cur_slot;
          hit = 1'b1;
        end
      end
      frkl_pkg::CMD_READ_NEXT: begin
        slot = next_slot;
        hit = 1'b1;
      end
      frkl_pkg::CMD_READ_LAST: begin
        slot = rm_r;
        hit = 1'b1;
      end
      default: begin
      end
    endcase
    unshown_nxt = (occ_nxt > CW'(shown_nxt)) ? occ_nxt - CW'(shown_nxt) : '0;
    waddr = IDX_W'(slot);
    addr_a = IDX_W'(slot);
    addr_b = IDX_W'(rm_nxt);
    // a push landing on the slot behind last_shown_pos is forwarded
    bypass = wr_en && (slot == rm_nxt);
  end

  frkl_ram #(
    .WIDTH(ENT_W),
    .DEPTH(RING_DEPTH)
  ) u_ram (
    .clk    (clk),
    .we     (cmd.exec && wr_en),
    .waddr  (waddr),
    .wdata  ({in_r.entry_pos, in_r.entry_serial}),
    .re     (cmd.exec),
    .raddr_a(addr_a),
    .raddr_b(addr_b),
    .rdata_a(rdata_a),
    .rdata_b(rdata_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= frkl_pkg::CAP_RESET;
      keep_r <= 1'b1;
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      wm_r <= '0;
      rm_r <= '0;
      occ_r <= '0;
      shown_r <= 1'b0;
      valid_r <= '0;
      norm_ok_r <= 1'b1;
      norm_busy_r <= 1'b0;
      norm_cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          frkl_pkg::CFG_RING_CAPACITY: begin
            cap_r <= cfg_wdata;
            norm_ok_r <= 1'b0;
          end
          frkl_pkg::CFG_KEEP_LAST: begin
            keep_r <= cfg_wdata[0];
          end
          default: begin
          end
        endcase
      end
      if (cmd.norm_start) begin
        norm_busy_r <= 1'b1;
        norm_cnt_r <= frkl_pkg::NORM_CNT_W'(CW - 1);
      end else if (norm_busy_r) begin
        norm_cnt_r <= norm_cnt_r - frkl_pkg::NORM_CNT_W'(1);
        if (norm_cnt_r == '0) begin
          norm_busy_r <= 1'b0;
          norm_ok_r <= 1'b1;
          rm_r <= remr_nxt;
          wm_r <= remw_nxt;
        end
      end
      if (cmd.exec) begin
        wr_idx_r <= wr_idx_nxt;
        wm_r <= wm_nxt;
        rd_idx_r <= rd_idx_nxt;
        rm_r <= rm_nxt;
        occ_r <= occ_nxt;
        shown_r <= shown_nxt;
        if (wr_en) begin
          valid_r[waddr] <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_r <= in_data;
    end
    if (cmd.norm_start) begin
      xr_r <= rd_idx_r;
      xw_r <= wr_idx_r;
      remr_r <= '0;
      remw_r <= '0;
    end else if (norm_busy_r) begin
      xr_r <= {xr_r[CW-2:0], 1'b0};
      xw_r <= {xw_r[CW-2:0], 1'b0};
      remr_r <= remr_nxt;
      remw_r <= remw_nxt;
    end
    if (cmd.exec) begin
      res_st_r <= st;
      res_slot_r <= slot;
      res_rem_r <= unshown_nxt;
      res_hit_r <= hit;
      res_shown_r <= shown_nxt;
      res_bypass_r <= bypass;
      va_r <= valid_r[addr_a];
      vb_r <= valid_r[addr_b];
    end
  end

  always_comb begin
    a_pos = va_r ? rdata_a[ENT_W-1:32] : '0;
    a_ser = va_r ? rdata_a[31:0] : '0;
    b_pos = vb_r ? rdata_b[ENT_W-1:32] : '0;
    b_ser = vb_r ? rdata_b[31:0] : '0;
    if (res_bypass_r) begin
      b_pos = in_r.entry_pos;
      b_ser = in_r.entry_serial;
    end
    res.status = res_st_r;
    res.slot_index = res_slot_r[3:0];
    res.read_pos = res_hit_r ? a_pos : '0;
    res.read_serial = res_hit_r ? a_ser : '0;
    res.remaining = res_rem_r;
    res.last_shown_pos = (res_shown_r && (b_ser == in_r.current_serial)) ? b_pos : '1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.resp_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp_load) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;
  assign stat.norm_ok = norm_ok_r;
  assign stat.out_free = !out_valid_r || !out_stall;

  a_shown_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
    shown_r |-> (occ_r != '0))
    else $error("shown flag set on an empty ring");

  a_exec_after_norm: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> (norm_ok_r && !norm_busy_r))
    else $error("command executed with unreduced indices");

  a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && wr_en) |=> (occ_r == $past(occ_r) + CW'(1)))
    else $error("accepted push did not raise occupancy");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !cmd.resp_load)
    else $error("result register overwritten while stalled");

endmodule
